// ===== sv/sts_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
package sts_pkg;

   // Field widths fixed by the item format
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned POS_W   = 10;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned MID_W   = COUNT_W;
   localparam int unsigned BOUND_W = COUNT_W + 1;

   // Command codes carried in tuser
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Search sequencer states
   typedef enum logic [1:0] {
      STS_IDLE,
      STS_CHECK,
      STS_DONE
   } sts_state_type;

endpackage

// ===== sv/sts_table.sv =====
// Table storage: one write port, one registered read port.
module sts_table
   import sts_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Store one entry per write beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // Register the probe read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sorted_table_binary_search.sv =====
// Top level: sorted table with binary search over a single-port-read memory.
//
// Input channel req_*: one beat per item. req_tuser is the command (0 write,
// 1 search); req_tdata carries the table address and the data word (entry
// value on a write, key on a search). A write is stored in the cycle it is
// accepted and gives no result. A search gives exactly one rsp_* beat:
// rsp_tuser is the found flag, rsp_tdata the matching index (0 if absent).
// The csr_* port sets entry_count, the number of sorted entries searched;
// write it only while no search is in progress.
// Timing: back-to-back writes are accepted. A search issues its first probe
// read in the accept cycle; in the check state each returned probe is
// compared and the next probe read issued (memory read plus one compare
// close the loop), then the done state hands the result to the output register.
// A search makes at most floor(log2(count)) + 1 probes. One search is in
// flight at a time.
// The output register holds a finished result while rsp_tready is low; the
// block still accepts writes meanwhile, and a following search waits only
// to deliver its own result. Reset clears control state and entry_count;
// table contents are undefined until written.
module sorted_table_binary_search
   import sts_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   // req_tdata: address [9:0], data [41:10], zero fill [47:42]
   input  logic [47:0]         req_tdata,
   // req_tuser: cmd [0]
   input  logic                req_tuser,
   input  logic                req_tvalid,
   output logic                req_tready,
   // rsp_tdata: position [9:0], zero fill [15:10]
   output logic [15:0]         rsp_tdata,
   // rsp_tuser: found [0]
   output logic                rsp_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Registers
   sts_state_type              state_ff, state_in;
   logic [COUNT_W-1:0]         count_ff;
   logic signed [BOUND_W-1:0]  low_ff, low_in;
   logic signed [BOUND_W-1:0]  high_ff, high_in;
   logic [MID_W-1:0]           mid_ff, mid_in;
   logic signed [DATA_W-1:0]   key_ff, key_in;
   logic                       found_ff, found_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]           rsp_pos_ff, rsp_pos_in;

   // Combinational
   logic                       req_accept;
   logic [POS_W-1:0]           req_address;
   logic signed [DATA_W-1:0]   req_data;
   logic [COUNT_W-1:0]         count_clamped;
   logic [MID_W-1:0]           mid_first;
   logic signed [DATA_W-1:0]   probe;
   logic                       hit;
   logic                       go_left;
   logic signed [BOUND_W-1:0]  low_nx, high_nx;
   logic                       carry_on;
   logic [BOUND_W:0]           bound_sum;
   logic [MID_W-1:0]           mid_nx;
   logic                       wr_en;
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_idx;
   logic [DATA_W-1:0]          rd_data;
   logic                       rsp_free;

   assign req_address = req_tdata[POS_W-1:0];
   assign req_data    = $signed(req_tdata[POS_W+DATA_W-1:POS_W]);
   assign req_accept  = req_tvalid && req_tready;
   assign req_tready  = (state_ff == STS_IDLE);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;

   // Clamp the count to the table depth
   always_comb begin
      if (32'(count_ff) > 32'(TABLE_DEPTH)) begin
         count_clamped = COUNT_W'(TABLE_DEPTH);
      end else begin
         count_clamped = count_ff;
      end
   end

   assign mid_first = MID_W'((count_clamped - COUNT_W'(1)) >> 1);

   // Compare the returned probe and narrow the bounds
   assign probe    = $signed(rd_data);
   assign hit      = (probe == key_ff);
   assign go_left  = (key_ff < probe);
   assign low_nx   = go_left ? low_ff : $signed({1'b0, mid_ff}) + BOUND_W'(1);
   assign high_nx  = go_left ? $signed({1'b0, mid_ff}) - BOUND_W'(1) : high_ff;
   assign carry_on = !hit && (low_nx <= high_nx);
   assign bound_sum = (BOUND_W+1)'($unsigned(low_nx)) + (BOUND_W+1)'($unsigned(high_nx));
   assign mid_nx    = bound_sum[MID_W:1];

   // Memory port control
   assign wr_en = req_accept && (req_tuser == CMD_WRITE)
                  && (32'(req_address) < 32'(TABLE_DEPTH));

   always_comb begin
      rd_en  = 1'b0;
      rd_idx = IDX_W'(mid_nx);
      if (state_ff == STS_IDLE) begin
         rd_idx = IDX_W'(mid_first);
         rd_en  = req_accept && (req_tuser == CMD_SEARCH) && (count_clamped != '0);
      end else if (state_ff == STS_CHECK) begin
         rd_en  = carry_on;
      end
   end

   sts_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (IDX_W'(req_address)),
      .wr_data (req_tdata[POS_W+DATA_W-1:POS_W]),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // Sequencer: next state, bounds and result
   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         STS_IDLE: begin
            if (req_accept && (req_tuser == CMD_SEARCH)) begin
               key_in  = req_data;
               low_in  = '0;
               high_in = $signed({1'b0, count_clamped}) - BOUND_W'(1);
               mid_in  = mid_first;
               if (count_clamped == '0) begin
                  found_in = 1'b0;
                  pos_in   = '0;
                  state_in = STS_DONE;
               end else begin
                  state_in = STS_CHECK;
               end
            end
         end
         STS_CHECK: begin
            low_in  = low_nx;
            high_in = high_nx;
            if (hit) begin
               found_in = 1'b1;
               pos_in   = mid_ff[POS_W-1:0];
               state_in = STS_DONE;
            end else if (!carry_on) begin
               found_in = 1'b0;
               pos_in   = '0;
               state_in = STS_DONE;
            end else begin
               mid_in = mid_nx;
            end
         end
         STS_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pos_in   = pos_ff;
               state_in     = STS_IDLE;
            end
         end
         default: begin
            state_in = STS_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STS_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(16 - POS_W)'(0), rsp_pos_ff};

   // A miss reports index zero
   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss reported with non-zero position");

   // A probe is only outstanding while the bounds are open
   a_check_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == STS_CHECK |-> low_ff <= high_ff)
      else $error("probe outstanding with empty bounds");

   // An accepted search blocks the input until it completes
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser == CMD_SEARCH |=> !req_tready)
      else $error("input accepted during a search");

   // A new result is loaded only from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == STS_DONE))
      else $error("result loaded outside the done state");

endmodule
